// File: hw/rtl/btpc_pkg.sv
// Package for the barometric compensation block: payload types, register
// indexes and datapath opcodes. No dependencies.
`default_nettype none
package btpc_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 64;

  typedef struct packed {
    logic        operation;
    logic [23:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic               reading_kind;
    logic signed [63:0] compensated_value;
  } out_item_t;

  localparam logic [1:0] RegTemp   = 2'd0;
  localparam logic [1:0] RegPWords = 2'd1;
  localparam logic [1:0] RegPBytes = 2'd2;
  localparam logic [1:0] RegPUns   = 2'd3;

  // Datapath micro-op: the multiplier operand sources and what is done with the product.
  typedef enum logic [5:0] {
    OpIdle,
    // temperature
    OpTd1, OpTd2, OpTd3, OpTd4, OpTd5, OpTd6, OpTout,
    // pressure
    OpPa, OpPb, OpPc, OpPd, OpPe, OpPf, OpPoff,
    OpSb, OpSd, OpSe, OpSens,
    OpQa, OpQb, OpQc, OpQd, OpQe, OpQf, OpQb2, OpQc2, OpQsum, OpPout
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
  } dp_cmd_t;

  function automatic logic [63:0] sdiv(input logic [63:0] v, input int unsigned sh);
    logic [63:0] m;
    m = (64'd0 - v) >> sh;
    return v[63] ? (64'd0 - m) : (v >> sh);
  endfunction

  function automatic logic [63:0] sx8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/btpc_mul.sv
// Shared 64x64 low-half multiplier, built from three 32x32 partial products
// accumulated serially. Does not depend on btpc_pkg.
`default_nettype none
module btpc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [2:0]  cnt_q;
  logic        busy_q;
  logic [31:0] x, y;
  logic [63:0] pp;

  always_comb begin
    x = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    y = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp = 64'(x) * 64'(y);
    unique case (cnt_q[1:0])
      2'd0: acc_d = pp;
      2'd1: acc_d = acc_q + {pp[31:0], 32'd0};
      2'd2: acc_d = acc_q + {pp[31:0], 32'd0};
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd2) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign p_o = acc_q;
endmodule
`default_nettype wire

// File: hw/rtl/btpc_datapath.sv
// Datapath: coefficient unpacking, scratch registers and fine temperature,
// feeding the shared multiplier. Depends on btpc_pkg and btpc_mul.
`default_nettype none
module btpc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btpc_pkg::dp_cmd_t   cmd_i,
  input  logic                start_i,
  output logic                done_o,
  input  btpc_pkg::in_item_t  item_i,
  input  logic [39:0]         temp_coef_i,
  input  logic [47:0]         pwords_i,
  input  logic [47:0]         pbytes_i,
  input  logic [31:0]         puns_i,
  output logic [63:0]         result_o
);
  import btpc_pkg::*;

  logic [63:0] raw_q, tf_q, tf_d;
  logic [63:0] r0_q, r1_q, r2_q, r3_q, off_q, sens_q, acc_q;
  logic [63:0] r0_d, r1_d, r2_d, r3_d, off_d, sens_d, acc_d;
  logic [63:0] ma, mb, p;
  logic        mdone;
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
  logic        mul_start;

  always_comb begin
    t1  = {48'd0, temp_coef_i[15:0]};
    t2  = {48'd0, temp_coef_i[31:16]};
    t3  = sx8(temp_coef_i[39:32]);
    p1  = sx16(pwords_i[15:0]);
    p2  = sx16(pwords_i[31:16]);
    p9  = sx16(pwords_i[47:32]);
    p3  = sx8(pbytes_i[7:0]);
    p4  = sx8(pbytes_i[15:8]);
    p7  = sx8(pbytes_i[23:16]);
    p8  = sx8(pbytes_i[31:24]);
    p10 = sx8(pbytes_i[39:32]);
    p11 = sx8(pbytes_i[47:40]);
    p5  = {48'd0, puns_i[15:0]};
    p6  = {48'd0, puns_i[31:16]};
  end

  // operand selection; r0 holds the live chain value, r1 holds a (tf*tf) or d1*d1*t3
  always_comb begin
    ma = tf_q;
    mb = tf_q;
    mul_start = 1'b0;
    unique case (cmd_i.op)
      OpTd2:  begin ma = t2;   mb = r0_q; mul_start = start_i; end
      OpTd3:  begin ma = r0_q; mb = r0_q; mul_start = start_i; end
      OpTd4:  begin ma = r2_q; mb = t3;   mul_start = start_i; end
      OpTout: begin ma = tf_q; mb = 64'd25; mul_start = start_i; end
      OpPa:   begin ma = tf_q; mb = tf_q; mul_start = start_i; end
      OpPb:   begin ma = sdiv(r1_q, 6); mb = tf_q; mul_start = start_i; end
      OpPc:   begin ma = p8;   mb = r0_q; mul_start = start_i; end
      OpPd:   begin ma = p7;   mb = r1_q; mul_start = start_i; end
      OpPe:   begin ma = p6;   mb = tf_q; mul_start = start_i; end
      OpSb:   begin ma = p4;   mb = r0_q; mul_start = start_i; end
      OpSd:   begin ma = p3;   mb = r1_q; mul_start = start_i; end
      OpSe:   begin ma = p2 - 64'd16384; mb = tf_q; mul_start = start_i; end
      OpQa:   begin ma = sdiv(sens_q, 24); mb = raw_q; mul_start = start_i; end
      OpQb:   begin ma = p10;  mb = tf_q; mul_start = start_i; end
      OpQc:   begin ma = r0_q; mb = raw_q; mul_start = start_i; end
      OpQd:   begin ma = sdiv(r0_q, 13); mb = raw_q; mul_start = start_i; end
      OpQe:   begin ma = raw_q; mb = raw_q; mul_start = start_i; end
      OpQf:   begin ma = p11;  mb = r0_q; mul_start = start_i; end
      OpQb2:  begin ma = sdiv(r0_q, 16); mb = raw_q; mul_start = start_i; end
      OpPout: begin ma = r0_q; mb = 64'd25; mul_start = start_i; end
      default: ;
    endcase
  end

  btpc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(p)
  );

  // product consumption (on mdone) or steps without the multiplier (on start)
  always_comb begin
    r0_d = r0_q; r1_d = r1_q; r2_d = r2_q; r3_d = r3_q;
    off_d = off_q; sens_d = sens_q; acc_d = acc_q; tf_d = tf_q;
    done_o = mdone;
    unique case (cmd_i.op)
      OpTd1: begin
        r0_d = raw_q - {t1[55:0], 8'd0};
        done_o = start_i;
      end
      OpTd2: if (mdone) r3_d = p;
      OpTd3: if (mdone) r2_d = p;
      OpTd4: if (mdone) r1_d = p;
      OpTd5: begin
        tf_d = sdiv({r3_q[45:0], 18'd0} + r1_q, 32);
        done_o = start_i;
      end
      OpTout: if (mdone) acc_d = sdiv(p, 14);
      OpPa: if (mdone) r1_d = p;
      OpPb: if (mdone) r0_d = sdiv(p, 8);
      OpPc: if (mdone) off_d = {p5[16:0], 47'd0} + sdiv(p, 5);
      OpPd: if (mdone) off_d = off_q + {p[59:0], 4'd0};
      OpPe: if (mdone) off_d = off_q + {p[41:0], 22'd0};
      OpSb: if (mdone) sens_d = {p1[17:0] - 18'd16384, 46'd0} + sdiv(p, 5);
      OpSd: if (mdone) sens_d = sens_q + {p[61:0], 2'd0};
      OpSe: if (mdone) sens_d = sens_q + {p[42:0], 21'd0};
      OpQa: if (mdone) acc_d = sdiv(off_q, 2) + p;
      OpQb: if (mdone) r0_d = p + {p9[47:0], 16'd0};
      OpQc: if (mdone) r0_d = p;
      OpQd: if (mdone) acc_d = acc_q + sdiv(p, 9);
      OpQe: if (mdone) r0_d = p;
      OpQf: if (mdone) r0_d = p;
      OpQb2: if (mdone) begin
        acc_d = acc_q + sdiv(p, 7);
        r0_d = acc_q + sdiv(p, 7);
      end
      OpPout: if (mdone) acc_d = p >> 40;
      default: done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tf_q <= '0;
    end else begin
      tf_q <= tf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) raw_q <= {40'd0, item_i.raw_reading};
    r0_q <= r0_d; r1_q <= r1_d; r2_q <= r2_d; r3_q <= r3_d;
    off_q <= off_d; sens_q <= sens_d; acc_q <= acc_d;
  end

  assign result_o = acc_q;
endmodule
`default_nettype wire

// File: hw/rtl/btpc_ctrl.sv
// Controller: steps the datapath through the micro-op sequence of one
// transaction and runs the handshakes. Depends on btpc_pkg.
`default_nettype none
module btpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output btpc_pkg::dp_cmd_t cmd_o,
  output logic              start_o,
  input  logic              done_i
);
  import btpc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [1:0] state_q, state_d;
  op_e        op_q, op_d, nxt;
  logic       kind_q, kind_d;
  logic       acc;

  always_comb begin
    unique case (op_q)
      OpTd1: nxt = OpTd2;
      OpTd2: nxt = OpTd3;
      OpTd3: nxt = OpTd4;
      OpTd4: nxt = OpTd5;
      OpTd5: nxt = OpTout;
      OpPa:  nxt = OpPb;
      OpPb:  nxt = OpPc;
      OpPc:  nxt = OpPd;
      OpPd:  nxt = OpPe;
      OpPe:  nxt = OpSb;
      OpSb:  nxt = OpSd;
      OpSd:  nxt = OpSe;
      OpSe:  nxt = OpQa;
      OpQa:  nxt = OpQb;
      OpQb:  nxt = OpQc;
      OpQc:  nxt = OpQd;
      OpQd:  nxt = OpQe;
      OpQe:  nxt = OpQf;
      OpQf:  nxt = OpQb2;
      OpQb2: nxt = OpPout;
      default: nxt = OpIdle;
    endcase
  end

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) && !(state_q == StOut && !out_stall_i);

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    kind_d = kind_q;
    unique case (state_q)
      StIdle: ;
      StIssue, StWait: begin
        if (done_i) begin
          if (nxt == OpIdle) state_d = StOut;
          else begin
            op_d = nxt;
            state_d = StIssue;
          end
        end else begin
          state_d = StWait;
        end
      end
      default: if (!out_stall_i) state_d = StIdle;
    endcase
    if (acc) begin
      state_d = StIssue;
      kind_d = in_op_i;
      op_d = in_op_i ? OpPa : OpTd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q <= OpIdle;
      kind_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      kind_q <= kind_d;
    end
  end

  assign cmd_o.op = op_q;
  assign cmd_o.load = acc;
  assign start_o = (state_q == StIssue);
  assign out_valid_o = (state_q == StOut);
  assign kind_o = kind_q;
endmodule
`default_nettype wire

// File: hw/rtl/baro_temp_press_compensation.sv
// Barometric temperature/pressure compensation, 64-bit integer scheme.
// One transaction at a time, the next accepted as the result leaves.
// The shared 64-bit multiplier is used serially for every product.
// Reset clears coefficient registers, fine temperature and control state.
`default_nettype none
module baro_temp_press_compensation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  btpc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output btpc_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import btpc_pkg::*;

  logic [39:0] temp_q;
  logic [47:0] pw_q, pb_q;
  logic [31:0] pu_q;
  dp_cmd_t     cmd;
  logic        start, done, kind;
  logic [63:0] res;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0; pw_q <= '0; pb_q <= '0; pu_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegTemp:   temp_q <= pwdata[39:0];
        RegPWords: pw_q <= pwdata[47:0];
        RegPBytes: pb_q <= pwdata[47:0];
        default:   pu_q <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegTemp:   prdata = {24'd0, temp_q};
      RegPWords: prdata = {16'd0, pw_q};
      RegPBytes: prdata = {16'd0, pb_q};
      default:   prdata = {32'd0, pu_q};
    endcase
  end

  btpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_op_i(in_data_i.operation), .in_stall_o,
    .out_valid_o, .out_stall_i, .kind_o(kind), .cmd_o(cmd), .start_o(start),
    .done_i(done)
  );

  btpc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .start_i(start), .done_o(done), .item_i(in_data_i),
    .temp_coef_i(temp_q), .pwords_i(pw_q), .pbytes_i(pb_q), .puns_i(pu_q),
    .result_o(res)
  );

  assign out_data_o.reading_kind = kind;
  assign out_data_o.compensated_value = res;
endmodule
`default_nettype wire

// File: sim/baro_temp_press_compensation_tb.sv
// Testbench for baro_temp_press_compensation: drives raw temperature and pressure
// transactions, programs the coefficient registers over APB and checks each result
// against an in-bench 64-bit integer predictor. Depends on btpc_pkg and the RTL.
`default_nettype none
module baro_temp_press_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  baro_temp_press_compensation u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0] coef_temp, coef_pwords, coef_pbytes, coef_puns, tfine;
  out_item_t result_q[$];
  int unsigned errors = 0, n_temp = 0, n_press = 0, n_checked = 0, cycles = 0;
  int unsigned hold_cycles = 0;
  bit stall_random = 1'b0;

  function automatic logic [63:0] shr_signed(logic [63:0] v, int unsigned sh);
    logic [63:0] m;
    m = (64'd0 - v) >> sh;
    if (v[63]) return 64'd0 - m;
    return v >> sh;
  endfunction

  function automatic logic [63:0] ext8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] ext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] temp_comp(logic [63:0] raw);
    logic [63:0] t1, t2, t3, d1, d5, d6;
    t1 = {48'd0, coef_temp[15:0]};
    t2 = {48'd0, coef_temp[31:16]};
    t3 = ext8(coef_temp[39:32]);
    d1 = raw - 64'd256 * t1;
    d5 = (t2 * d1) * 64'd262144 + (d1 * d1) * t3;
    d6 = shr_signed(d5, 32);
    tfine = d6;
    return shr_signed(d6 * 64'd25, 14);
  endfunction

  function automatic logic [63:0] press_comp(logic [63:0] raw);
    logic [63:0] p1, p2, p9, p3, p4, p7, p8, p10, p11, p5, p6, tf;
    logic [63:0] a, b, c, d, e, f, offs, sens;
    p1 = ext16(coef_pwords[15:0]);
    p2 = ext16(coef_pwords[31:16]);
    p9 = ext16(coef_pwords[47:32]);
    p3 = ext8(coef_pbytes[7:0]);
    p4 = ext8(coef_pbytes[15:8]);
    p7 = ext8(coef_pbytes[23:16]);
    p8 = ext8(coef_pbytes[31:24]);
    p10 = ext8(coef_pbytes[39:32]);
    p11 = ext8(coef_pbytes[47:40]);
    p5 = {48'd0, coef_puns[15:0]};
    p6 = {48'd0, coef_puns[31:16]};
    tf = tfine;
    a = tf * tf;
    b = shr_signed(a, 6);
    c = shr_signed(b * tf, 8);
    d = shr_signed(p8 * c, 5);
    e = p7 * a * 64'd16;
    f = p6 * tf * 64'd4194304;
    offs = p5 * 64'd140737488355328 + d + e + f;
    b = shr_signed(p4 * c, 5);
    d = p3 * a * 64'd4;
    e = (p2 - 64'd16384) * tf * 64'd2097152;
    sens = (p1 - 64'd16384) * 64'd70368744177664 + b + d + e;
    a = shr_signed(sens, 24) * raw;
    b = p10 * tf;
    c = b + 64'd65536 * p9;
    d = shr_signed(c * raw, 13);
    e = shr_signed(d * raw, 9);
    f = raw * raw;
    b = shr_signed(p11 * f, 16);
    c = shr_signed(b * raw, 7);
    d = shr_signed(offs, 2) + a + e + c;
    return (d * 64'd25) >> 40;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegTemp: coef_temp = value & 64'hFF_FFFF_FFFF;
      RegPWords: coef_pwords = value & 64'hFFFF_FFFF_FFFF;
      RegPBytes: coef_pbytes = value & 64'hFFFF_FFFF_FFFF;
      default: coef_puns = value & 64'hFFFF_FFFF;
    endcase
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic configure(logic [63:0] t, logic [63:0] w, logic [63:0] b, logic [63:0] u);
    drain();
    apb_write(RegTemp, t);
    apb_write(RegPWords, w);
    apb_write(RegPBytes, b);
    apb_write(RegPUns, u);
  endtask

  // Drives one transaction, holds it until accepted; keep_valid leaves valid up.
  task automatic send_reading(logic op, logic [23:0] raw, bit keep_valid);
    out_item_t exp_item;
    in_data_i <= '{operation: op, raw_reading: raw};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    exp_item.reading_kind = op;
    if (op) begin
      exp_item.compensated_value = press_comp({40'd0, raw});
      n_press++;
    end else begin
      exp_item.compensated_value = temp_comp({40'd0, raw});
      n_temp++;
    end
    result_q.push_back(exp_item);
    if (!keep_valid) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned count, int unsigned press_pct);
    int unsigned burst, gap;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        burst--; count--;
        send_reading($urandom_range(99, 0) < press_pct, 24'($urandom()),
                     burst > 0 && count > 0);
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_defaults();
    send_reading(1'b1, 24'h000000, 1'b0);
    send_reading(1'b1, 24'hFFFFFF, 1'b0);
    send_reading(1'b0, 24'h000000, 1'b0);
    send_reading(1'b0, 24'hFFFFFF, 1'b0);
  endtask

  task automatic test_directed_extremes();
    configure(64'h6B_66A0_6CE6, 64'h0AB4_FFF5_F67C, 64'h1E_F6_FF_03_0F_F7,
              64'h5A3E_C8A0);
    send_reading(1'b0, 24'h7E1F40, 1'b0);
    send_reading(1'b1, 24'h6A2C80, 1'b0);
    send_reading(1'b0, 24'h000000, 1'b0);
    send_reading(1'b1, 24'hFFFFFF, 1'b0);
    send_reading(1'b1, 24'h000000, 1'b0);
    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_reading(1'b0, 24'hFFFFFF, 1'b0);
    send_reading(1'b1, 24'hFFFFFF, 1'b0);
    send_reading(1'b0, 24'h000001, 1'b0);
    send_reading(1'b1, 24'h800000, 1'b0);
    configure(64'h80_0000_0000, 64'h8000_8000_8000, 64'h80_80_80_80_80_80,
              64'h8000_0000);
    send_reading(1'b0, 24'h800000, 1'b0);
    send_reading(1'b1, 24'h7FFFFF, 1'b0);
    configure(64'h7F_FFFF_FFFF, 64'h7FFF_7FFF_7FFF, 64'h7F_7F_7F_7F_7F_7F,
              64'h0000_FFFF);
    send_reading(1'b0, 24'h555555, 1'b0);
    send_reading(1'b1, 24'hAAAAAA, 1'b0);
    send_reading(1'b1, 24'h555555, 1'b0);
  endtask

  task automatic test_random_coefficients();
    repeat (6) begin
      configure(rand64(), rand64(), rand64(), rand64());
      stall_random = 1'b1;
      send_random(55, 50);
    end
  endtask

  task automatic test_output_backpressure();
    configure(64'h6B_66A0_6CE6, 64'h0AB4_FFF5_F67C, 64'h1E_F6_FF_03_0F_F7,
              64'h5A3E_C8A0);
    hold_cycles = 600;
    send_random(20, 50);
    send_random(50, 60);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= stall_random && ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("unexpected result kind=%0d value=%0h", out_data_o.reading_kind,
               out_data_o.compensated_value);
        errors++;
      end else begin
        exp_item = result_q.pop_front();
        n_checked++;
        if (out_data_o.reading_kind !== exp_item.reading_kind) begin
          $error("reading_kind expected %0d actual %0d", exp_item.reading_kind,
                 out_data_o.reading_kind);
          errors++;
        end
        if (out_data_o.compensated_value !== exp_item.compensated_value) begin
          $error("compensated_value expected %0h actual %0h",
                 exp_item.compensated_value, out_data_o.compensated_value);
          errors++;
        end
      end
    end
  end

  initial begin
    coef_temp = '0; coef_pwords = '0; coef_pbytes = '0; coef_puns = '0; tfine = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_coefficients();
    test_output_backpressure();
    drain();
    if (result_q.size() != 0) errors++;
    $display("Covered %0d temperature and %0d pressure transactions, %0d results checked",
             n_temp, n_press, n_checked);
    $display("across reset, extreme and random coefficient sets with output holds.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
